@@ src/state_variable_filter_unit_macros.svh @@
// Assertion macros for the state variable filter checker.
// Expects signals named clk and rst in the scope of use.
`ifndef STATE_VARIABLE_FILTER_UNIT_MACROS_SVH
`define STATE_VARIABLE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define SVF_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svf check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define SVF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svf check failed");

`endif

@@ src/svf_pkg.sv @@
// Shared types, constants and saturation helpers for the state variable filter.
// No dependencies; every other file of the block but the assertion macros header uses it.
package svf_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int INNER_W         = 38;
  localparam int STATE_W         = 32;
  localparam int WIDE_W          = 64;
  localparam int G_FRAC          = 18;
  localparam int K_FRAC          = 22;
  localparam int INV_FRAC        = 23;
  localparam int CFG_W           = 24;
  localparam int CFG_IDX_W       = 2;
  localparam int MODE_W          = 2;
  localparam int G_W             = 23;
  localparam int K_W             = 24;
  localparam int INV_W           = 24;
  localparam int COEF_W          = 25;

  typedef logic signed [WIDE_W-1:0]  svf_wide_t;
  typedef logic signed [INNER_W-1:0] svf_inner_t;
  typedef logic signed [STATE_W-1:0] svf_state_t;

  localparam svf_wide_t INNER_MAX = (64'sd1 <<< (INNER_W - 1)) - 64'sd1;
  localparam svf_wide_t INNER_MIN = -INNER_MAX - 64'sd1;
  localparam svf_wide_t STATE_MAX = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
  localparam svf_wide_t STATE_MIN = -STATE_MAX - 64'sd1;
  localparam svf_wide_t G_HALF    = 64'sd1 <<< (G_FRAC - 1);
  localparam svf_wide_t K_HALF    = 64'sd1 <<< (K_FRAC - 1);
  localparam svf_wide_t INV_HALF  = 64'sd1 <<< (INV_FRAC - 1);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_G    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV  = 2'd3;

  localparam logic [G_W-1:0]   G_RST   = 23'd17182;
  localparam logic [K_W-1:0]   K_RST   = 24'd4194304;
  localparam logic [INV_W-1:0] INV_RST = 24'd7841013;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOW   = 2'd0,
    MODE_HIGH  = 2'd1,
    MODE_BAND  = 2'd2,
    MODE_NOTCH = 2'd3
  } svf_mode_t;

  // One step per product on the shared multiplier
  typedef enum logic [2:0] {
    STEP_G_V3    = 3'd0,
    STEP_INV_V1N = 3'd1,
    STEP_K_HP    = 3'd2,
    STEP_INV_HP  = 3'd3,
    STEP_G_BP    = 3'd4,
    STEP_G_LP    = 3'd5
  } svf_step_t;

  typedef struct packed {
    logic      load;
    logic      mul;
    logic      post;
    logic      finish;
    svf_step_t step;
  } svf_cmd_t;

  function automatic svf_step_t step_next(svf_step_t s);
    case (s)
      STEP_G_V3:    return STEP_INV_V1N;
      STEP_INV_V1N: return STEP_K_HP;
      STEP_K_HP:    return STEP_INV_HP;
      STEP_INV_HP:  return STEP_G_BP;
      STEP_G_BP:    return STEP_G_LP;
      default:      return STEP_G_V3;
    endcase
  endfunction

  function automatic svf_inner_t sat_inner(svf_wide_t v);
    if (v > INNER_MAX) return svf_inner_t'(INNER_MAX);
    if (v < INNER_MIN) return svf_inner_t'(INNER_MIN);
    return svf_inner_t'(v);
  endfunction

  function automatic svf_state_t sat_state(svf_wide_t v);
    if (v > STATE_MAX) return svf_state_t'(STATE_MAX);
    if (v < STATE_MIN) return svf_state_t'(STATE_MIN);
    return svf_state_t'(v);
  endfunction

endpackage

@@ src/svf_if.sv @@
// Stream interfaces for the state variable filter: sample in, responses out.
// Depends on svf_pkg for the default sample width.
interface svf_in_if #(
  parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface svf_out_if #(
  parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic signed [SAMPLE_BITS-1:0] low_out;
  logic signed [SAMPLE_BITS-1:0] high_out;
  logic signed [SAMPLE_BITS-1:0] band_out;
  logic signed [SAMPLE_BITS-1:0] notch_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output low_out, output high_out,
                  output band_out, output notch_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input low_out, input high_out,
                  input band_out, input notch_out, input clipped, output ready);
endinterface

@@ src/state_variable_filter_unit.sv @@
// Top level of the trapezoidal state variable filter: configuration registers,
// sequencer and datapath. Depends on svf_pkg, svf_if, svf_ctrl and svf_dp.
//
//   port   | direction | carries
//   -------+-----------+---------------------------------------------------
//   din    | sink      | sample_in, one Q1.23 sample per transaction
//   dout   | source    | sample_out, low/high/band/notch_out, clipped
//   cfg_*  | write     | mode, g_coef, damping_k, inv_denominator
//
// One sample runs the load, then six products on the shared
// 38x25 multiplier, each a multiply step and then a round and add step,
// then the finish that writes the output register and the integrators.
// din is ready again in the same cycle that the result shows. A stalled dout
// holds the finish step only; the next sample may be taken while a result
// waits. rst is synchronous and clears control, integrators and registers
// to their defaults.
module state_variable_filter_unit #(
  parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  svf_in_if.sink                           din,
  svf_out_if.source                        dout,
  input  logic                             cfg_we,
  input  logic [svf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svf_pkg::CFG_W-1:0]        cfg_data
);

  logic [svf_pkg::MODE_W-1:0] mode;
  logic [svf_pkg::G_W-1:0]    g_coef;
  logic [svf_pkg::K_W-1:0]    damping_k;
  logic [svf_pkg::INV_W-1:0]  inv_denominator;
  svf_pkg::svf_cmd_t          cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= svf_pkg::MODE_LOW;
      g_coef          <= svf_pkg::G_RST;
      damping_k       <= svf_pkg::K_RST;
      inv_denominator <= svf_pkg::INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svf_pkg::REG_MODE: mode            <= cfg_data[svf_pkg::MODE_W-1:0];
        svf_pkg::REG_G:    g_coef          <= cfg_data[svf_pkg::G_W-1:0];
        svf_pkg::REG_K:    damping_k       <= cfg_data[svf_pkg::K_W-1:0];
        svf_pkg::REG_INV:  inv_denominator <= cfg_data[svf_pkg::INV_W-1:0];
      endcase
    end
  end

  svf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .cmd       (cmd)
  );

  svf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sample_in       (din.sample_in),
    .mode            (mode),
    .g_coef          (g_coef),
    .damping_k       (damping_k),
    .inv_denominator (inv_denominator),
    .sample_out      (dout.sample_out),
    .low_out         (dout.low_out),
    .high_out        (dout.high_out),
    .band_out        (dout.band_out),
    .notch_out       (dout.notch_out),
    .clipped         (dout.clipped)
  );

endmodule

@@ src/svf_ctrl.sv @@
// Sequencer for the state variable filter: walks the six products and hands
// the result to the output register. Depends on svf_pkg.
module svf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output svf_pkg::svf_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_POST,
    ST_FINISH
  } state_t;

  state_t              state;
  svf_pkg::svf_step_t  step;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.mul    = (state == ST_MUL);
    cmd.post   = (state == ST_POST);
    // hold the finish until the output register is free or draining
    cmd.finish = (state == ST_FINISH) && (!out_valid || out_ready);
    cmd.step   = step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= svf_pkg::STEP_G_V3;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_MUL;
            step  <= svf_pkg::STEP_G_V3;
          end
        end
        ST_MUL: begin
          state <= ST_POST;
        end
        ST_POST: begin
          if (step == svf_pkg::STEP_G_LP) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_MUL;
            step  <= svf_pkg::step_next(step);
          end
        end
        ST_FINISH: begin
          if (cmd.finish) begin
            state <= ST_IDLE;
          end
        end
      endcase
      out_valid <= cmd.finish | (out_valid & ~out_ready);
    end
  end

endmodule

@@ src/svf_dp.sv @@
// Datapath of the state variable filter: one shared multiplier, rounding and
// saturation, integrator states and the output register. Depends on svf_pkg.
module svf_dp #(
  parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  svf_pkg::svf_cmd_t                 cmd,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in,
  input  logic [svf_pkg::MODE_W-1:0]        mode,
  input  logic [svf_pkg::G_W-1:0]           g_coef,
  input  logic [svf_pkg::K_W-1:0]           damping_k,
  input  logic [svf_pkg::INV_W-1:0]         inv_denominator,
  output logic signed [SAMPLE_BITS-1:0]     sample_out,
  output logic signed [SAMPLE_BITS-1:0]     low_out,
  output logic signed [SAMPLE_BITS-1:0]     high_out,
  output logic signed [SAMPLE_BITS-1:0]     band_out,
  output logic signed [SAMPLE_BITS-1:0]     notch_out,
  output logic                              clipped
);

  localparam int PROD_W = svf_pkg::INNER_W + svf_pkg::COEF_W;
  localparam svf_pkg::svf_inner_t SMAX =
    svf_pkg::svf_inner_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam svf_pkg::svf_inner_t SMIN = ~SMAX;

  // {clip, value}
  function automatic logic [SAMPLE_BITS:0] sat_sample(svf_pkg::svf_inner_t v);
    if (v > SMAX) return {1'b1, SMAX[SAMPLE_BITS-1:0]};
    if (v < SMIN) return {1'b1, SMIN[SAMPLE_BITS-1:0]};
    return {1'b0, v[SAMPLE_BITS-1:0]};
  endfunction

  svf_pkg::svf_inner_t        x_r;
  svf_pkg::svf_inner_t        opa;
  svf_pkg::svf_inner_t        hp_r;
  svf_pkg::svf_inner_t        bp_r;
  svf_pkg::svf_inner_t        lp_r;
  svf_pkg::svf_state_t        s1;
  svf_pkg::svf_state_t        s2;
  logic signed [PROD_W-1:0]   prod;
  logic signed [svf_pkg::COEF_W-1:0] coef;

  svf_pkg::svf_wide_t         pw;
  svf_pkg::svf_inner_t        rnd;
  svf_pkg::svf_inner_t        add_s1;
  svf_pkg::svf_inner_t        add_s2;
  svf_pkg::svf_inner_t        hp_pre;
  svf_pkg::svf_inner_t        hp_new;
  svf_pkg::svf_inner_t        v3;
  svf_pkg::svf_inner_t        notch;
  svf_pkg::svf_state_t        s1_next;
  svf_pkg::svf_state_t        s2_next;
  logic [SAMPLE_BITS:0]       lo_sat;
  logic [SAMPLE_BITS:0]       hi_sat;
  logic [SAMPLE_BITS:0]       bd_sat;
  logic [SAMPLE_BITS:0]       nt_sat;
  logic [SAMPLE_BITS-1:0]     sel;

  always_comb begin
    case (cmd.step) inside
      svf_pkg::STEP_INV_V1N, svf_pkg::STEP_INV_HP:
        coef = svf_pkg::COEF_W'({1'b0, inv_denominator});
      svf_pkg::STEP_K_HP:
        coef = svf_pkg::COEF_W'({1'b0, damping_k});
      default:
        coef = svf_pkg::COEF_W'({2'b00, g_coef});
    endcase
  end

  // Round half up, floor shift back to the sample fraction, saturate
  always_comb begin
    pw = svf_pkg::svf_wide_t'(prod);
    case (cmd.step) inside
      svf_pkg::STEP_INV_V1N, svf_pkg::STEP_INV_HP:
        rnd = svf_pkg::sat_inner((pw + svf_pkg::INV_HALF) >>> svf_pkg::INV_FRAC);
      svf_pkg::STEP_K_HP:
        rnd = svf_pkg::sat_inner((pw + svf_pkg::K_HALF) >>> svf_pkg::K_FRAC);
      default:
        rnd = svf_pkg::sat_inner((pw + svf_pkg::G_HALF) >>> svf_pkg::G_FRAC);
    endcase
    add_s1 = svf_pkg::sat_inner(svf_pkg::svf_wide_t'(rnd) + svf_pkg::svf_wide_t'(s1));
    add_s2 = svf_pkg::sat_inner(svf_pkg::svf_wide_t'(rnd) + svf_pkg::svf_wide_t'(s2));
    hp_pre = svf_pkg::sat_inner(svf_pkg::svf_wide_t'(x_r) - svf_pkg::svf_wide_t'(rnd));
    hp_new = svf_pkg::sat_inner(svf_pkg::svf_wide_t'(hp_pre) - svf_pkg::svf_wide_t'(s2));
    v3     = svf_pkg::sat_inner(svf_pkg::svf_wide_t'(sample_in)
                                - svf_pkg::svf_wide_t'(s2));
  end

  always_comb begin
    notch   = svf_pkg::sat_inner(svf_pkg::svf_wide_t'(hp_r) + svf_pkg::svf_wide_t'(lp_r));
    s1_next = svf_pkg::sat_state((svf_pkg::svf_wide_t'(bp_r) <<< 1)
                                 - svf_pkg::svf_wide_t'(s1));
    s2_next = svf_pkg::sat_state((svf_pkg::svf_wide_t'(lp_r) <<< 1)
                                 - svf_pkg::svf_wide_t'(s2));
    lo_sat  = sat_sample(lp_r);
    hi_sat  = sat_sample(hp_r);
    bd_sat  = sat_sample(bp_r);
    nt_sat  = sat_sample(notch);
    case (svf_pkg::svf_mode_t'(mode))
      svf_pkg::MODE_HIGH:  sel = hi_sat[SAMPLE_BITS-1:0];
      svf_pkg::MODE_BAND:  sel = bd_sat[SAMPLE_BITS-1:0];
      svf_pkg::MODE_NOTCH: sel = nt_sat[SAMPLE_BITS-1:0];
      default:             sel = lo_sat[SAMPLE_BITS-1:0];
    endcase
  end

  // Integrator states
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else if (cmd.finish) begin
      s1 <= s1_next;
      s2 <= s2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= svf_pkg::svf_inner_t'(sample_in);
      opa <= v3;
    end
    if (cmd.mul) begin
      prod <= opa * coef;
    end
    if (cmd.post) begin
      case (cmd.step)
        svf_pkg::STEP_G_V3:    opa <= rnd;
        svf_pkg::STEP_INV_V1N: opa <= add_s1;
        svf_pkg::STEP_K_HP:    opa <= hp_new;
        svf_pkg::STEP_INV_HP: begin
          opa  <= rnd;
          hp_r <= rnd;
        end
        svf_pkg::STEP_G_BP: begin
          opa  <= add_s1;
          bp_r <= add_s1;
        end
        svf_pkg::STEP_G_LP:    lp_r <= add_s2;
        default: ;
      endcase
    end
    if (cmd.finish) begin
      sample_out <= sel;
      low_out    <= lo_sat[SAMPLE_BITS-1:0];
      high_out   <= hi_sat[SAMPLE_BITS-1:0];
      band_out   <= bd_sat[SAMPLE_BITS-1:0];
      notch_out  <= nt_sat[SAMPLE_BITS-1:0];
      clipped    <= lo_sat[SAMPLE_BITS] | hi_sat[SAMPLE_BITS]
                    | bd_sat[SAMPLE_BITS] | nt_sat[SAMPLE_BITS];
    end
  end

endmodule

@@ src/svf_checker.sv @@
// Port-level checks for the state variable filter, bound to the top level.
// Depends on svf_pkg and state_variable_filter_unit_macros.svh.
`include "state_variable_filter_unit_macros.svh"

module svf_checker #(
  parameter int SAMPLE_BITS = svf_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic signed [SAMPLE_BITS-1:0] low_out,
  input logic signed [SAMPLE_BITS-1:0] high_out,
  input logic signed [SAMPLE_BITS-1:0] band_out,
  input logic signed [SAMPLE_BITS-1:0] notch_out,
  input logic                          clipped
);

  logic [5*SAMPLE_BITS:0] out_word;
  logic                   sel_is_resp;

  assign out_word    = {sample_out, low_out, high_out, band_out, notch_out, clipped};
  assign sel_is_resp = (sample_out == low_out) || (sample_out == high_out)
                       || (sample_out == band_out) || (sample_out == notch_out);

  // a sample in work blocks the next one
  `SVF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a stalled result stays put
  `SVF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // the selected response is always one of the four
  `SVF_ASSERT_IMPL(a_sel_match, out_valid, sel_is_resp)

endmodule

bind state_variable_filter_unit svf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_svf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .sample_out (dout.sample_out),
  .low_out    (dout.low_out),
  .high_out   (dout.high_out),
  .band_out   (dout.band_out),
  .notch_out  (dout.notch_out),
  .clipped    (dout.clipped)
);

@@ tb/tb_state_variable_filter_unit.sv @@
// Self-checking testbench for state_variable_filter_unit: feeds audio samples,
// writes the coefficient registers between phases, predicts every response set.
// Depends on svf_pkg, the svf_in_if/svf_out_if interfaces and the filter RTL.

module tb_state_variable_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [svf_pkg::SAMPLE_BITS_DEF-1:0] sample_t;
  typedef logic [svf_pkg::CFG_W-1:0] cfg_word_t;

  typedef struct packed {
    logic signed [svf_pkg::SAMPLE_BITS_DEF-1:0] sel_resp;
    logic signed [svf_pkg::SAMPLE_BITS_DEF-1:0] low_resp;
    logic signed [svf_pkg::SAMPLE_BITS_DEF-1:0] high_resp;
    logic signed [svf_pkg::SAMPLE_BITS_DEF-1:0] band_resp;
    logic signed [svf_pkg::SAMPLE_BITS_DEF-1:0] notch_resp;
    logic                                       clip;
  } filter_responses_t;

  class filter_scoreboard;
    localparam int MAX_REPORTS = 10;

    svf_pkg::svf_mode_t         mode;
    logic [svf_pkg::G_W-1:0]    g_coef;
    logic [svf_pkg::K_W-1:0]    damping;
    logic [svf_pkg::INV_W-1:0]  inv_den;
    longint                     integ1;
    longint                     integ2;
    filter_responses_t          expected_responses[$];
    int unsigned                failures;

    function new();
      mode     = svf_pkg::MODE_LOW;
      g_coef   = svf_pkg::G_RST;
      damping  = svf_pkg::K_RST;
      inv_den  = svf_pkg::INV_RST;
      integ1   = 0;
      integ2   = 0;
      failures = 0;
    endfunction

    function void set_register(logic [svf_pkg::CFG_IDX_W-1:0] idx, cfg_word_t data);
      case (idx)
        svf_pkg::REG_MODE: mode = svf_pkg::svf_mode_t'(data[svf_pkg::MODE_W-1:0]);
        svf_pkg::REG_G:    g_coef = data[svf_pkg::G_W-1:0];
        svf_pkg::REG_K:    damping = data[svf_pkg::K_W-1:0];
        svf_pkg::REG_INV:  inv_den = data[svf_pkg::INV_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      if (v > hi) return hi;
      if (v < -hi - 64'sd1) return -hi - 64'sd1;
      return v;
    endfunction

    // Product rounded half up to the sample format, then held to the inner width
    function longint scale(longint v, longint coef, int sh);
      longint p;
      p = v * coef;
      p = (p + (64'sd1 <<< (sh - 1))) >>> sh;
      return clamp(p, svf_pkg::INNER_W);
    endfunction

    function void note_sample(sample_t x);
      longint xs, v3, v1n, hp, bp, lp, nt;
      filter_responses_t r;
      xs  = x;
      v3  = clamp(xs - integ2, svf_pkg::INNER_W);
      v1n = clamp(scale(scale(v3, g_coef, svf_pkg::G_FRAC), inv_den, svf_pkg::INV_FRAC)
                  + integ1, svf_pkg::INNER_W);
      hp  = clamp(xs - scale(v1n, damping, svf_pkg::K_FRAC), svf_pkg::INNER_W);
      hp  = clamp(hp - integ2, svf_pkg::INNER_W);
      hp  = scale(hp, inv_den, svf_pkg::INV_FRAC);
      bp  = clamp(scale(hp, g_coef, svf_pkg::G_FRAC) + integ1, svf_pkg::INNER_W);
      lp  = clamp(scale(bp, g_coef, svf_pkg::G_FRAC) + integ2, svf_pkg::INNER_W);
      nt  = clamp(hp + lp, svf_pkg::INNER_W);
      integ1 = clamp(2 * bp - integ1, svf_pkg::STATE_W);
      integ2 = clamp(2 * lp - integ2, svf_pkg::STATE_W);
      r.low_resp   = sample_t'(clamp(lp, svf_pkg::SAMPLE_BITS_DEF));
      r.high_resp  = sample_t'(clamp(hp, svf_pkg::SAMPLE_BITS_DEF));
      r.band_resp  = sample_t'(clamp(bp, svf_pkg::SAMPLE_BITS_DEF));
      r.notch_resp = sample_t'(clamp(nt, svf_pkg::SAMPLE_BITS_DEF));
      r.clip = (clamp(lp, svf_pkg::SAMPLE_BITS_DEF) != lp)
               || (clamp(hp, svf_pkg::SAMPLE_BITS_DEF) != hp)
               || (clamp(bp, svf_pkg::SAMPLE_BITS_DEF) != bp)
               || (clamp(nt, svf_pkg::SAMPLE_BITS_DEF) != nt);
      case (mode)
        svf_pkg::MODE_HIGH:  r.sel_resp = r.high_resp;
        svf_pkg::MODE_BAND:  r.sel_resp = r.band_resp;
        svf_pkg::MODE_NOTCH: r.sel_resp = r.notch_resp;
        default:             r.sel_resp = r.low_resp;
      endcase
      expected_responses.push_back(r);
    endfunction

    function void compare_field(string name, longint e, longint a);
      if (e != a) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%t %s mismatch: expected %0d, got %0d", $time, name, e, a);
      end
    endfunction

    function void check_responses(filter_responses_t act);
      filter_responses_t e;
      if (expected_responses.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%t response set with no sample outstanding", $time);
        return;
      end
      e = expected_responses.pop_front();
      compare_field("sample_out", e.sel_resp, act.sel_resp);
      compare_field("low_out", e.low_resp, act.low_resp);
      compare_field("high_out", e.high_resp, act.high_resp);
      compare_field("band_out", e.band_resp, act.band_resp);
      compare_field("notch_out", e.notch_resp, act.notch_resp);
      compare_field("clipped", longint'(e.clip), longint'(act.clip));
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction
  endclass

  localparam int STALL_LIMIT     = 5000;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int SETTLE_CYCLES   = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [svf_pkg::CFG_IDX_W-1:0] cfg_index;
  cfg_word_t                     cfg_data;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_off_reqs = 0;
  int unsigned stall_cycles;

  filter_scoreboard board = new();

  svf_in_if  din_if ();
  svf_out_if dout_if ();

  state_variable_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .din       (din_if),
    .dout      (dout_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random back-pressure, plus a long hold-off on request
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    dout_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_reqs != hold_seen) begin
        hold_seen = hold_off_reqs;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        dout_if.ready = 1'b0;
        hold_left--;
      end else begin
        dout_if.ready = ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Check every output transaction; end the run if nothing moves for too long
  initial begin
    filter_responses_t got;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst && dout_if.valid && dout_if.ready) begin
        got.sel_resp   = dout_if.sample_out;
        got.low_resp   = dout_if.low_out;
        got.high_resp  = dout_if.high_out;
        got.band_resp  = dout_if.band_out;
        got.notch_resp = dout_if.notch_out;
        got.clip       = dout_if.clipped;
        board.check_responses(got);
      end
      if (!rst && ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic cfg_word_t inv_for(longint g, longint k);
    longint d;
    d = (64'sd1 <<< 36) + g * g + ((g * k) >>> 4);
    return cfg_word_t'((64'sd1 <<< 59) / d);
  endfunction

  task automatic write_reg(input logic [svf_pkg::CFG_IDX_W-1:0] idx, input cfg_word_t data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_register(idx, data);
  endtask

  task automatic configure(input cfg_word_t m, input cfg_word_t g,
                           input cfg_word_t k, input cfg_word_t inv);
    write_reg(svf_pkg::REG_MODE, m);
    write_reg(svf_pkg::REG_G, g);
    write_reg(svf_pkg::REG_K, k);
    write_reg(svf_pkg::REG_INV, inv);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic put_sample(input sample_t x);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      din_if.valid = 1'b0;
      @(negedge clk);
    end
    din_if.valid     = 1'b1;
    din_if.sample_in = x;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    board.note_sample(x);
    @(negedge clk);
  endtask

  task automatic drain();
    din_if.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    cfg_word_t   gv;
    cfg_word_t   kv;
    sample_t     x;
    sample_t     last_x;
    int unsigned pick;

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = svf_pkg::REG_MODE;
    cfg_data         = '0;
    din_if.valid     = 1'b0;
    din_if.sample_in = '0;
    last_x           = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset coefficients, lowpass
    put_sample(24'sd0);
    put_sample(SAMPLE_MAX);
    put_sample(SAMPLE_MIN);
    put_sample(-24'sd1);
    put_sample(24'sd1);
    put_sample(SAMPLE_MAX);
    drain();

    // All coefficients zero, highpass
    configure(cfg_word_t'(svf_pkg::MODE_HIGH), '0, '0, '0);
    put_sample(SAMPLE_MAX);
    put_sample(SAMPLE_MIN);
    drain();

    // Largest tuning, unity reciprocal: drive integrators and outputs to their limits
    configure(cfg_word_t'(svf_pkg::MODE_BAND), 24'h7FFFFF, 24'h800000, 24'h800000);
    repeat (3) put_sample(SAMPLE_MAX);
    repeat (3) put_sample(SAMPLE_MIN);
    drain();

    // All ones on every register: bits above each width are dropped, reciprocal gains
    configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    put_sample(SAMPLE_MAX);
    put_sample(SAMPLE_MIN);
    put_sample(SAMPLE_MAX);
    put_sample(24'sd0);
    drain();

    // Resonant lowpass step response
    configure(cfg_word_t'(svf_pkg::MODE_LOW), 24'h010000, 24'h080000,
              inv_for(24'h010000, 24'h080000));
    repeat (4) put_sample(SAMPLE_MAX);
    put_sample(24'sd0);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 4) begin
        src_idle_pct = 15;
        snk_idle_pct = 61;
      end else if (ph < 8) begin
        src_idle_pct = 61;
        snk_idle_pct = 15;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end

      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        // Realistic filter: reciprocal matches tuning and damping
        gv = cfg_word_t'($urandom_range(1, 1 << $urandom_range(8, 21)));
        kv = cfg_word_t'($urandom_range(0, 1 << 23));
        configure(cfg_word_t'($urandom_range(0, 3)), gv, kv, inv_for(gv, kv));
      end else if (pick < 9) begin
        configure(cfg_word_t'($urandom()), cfg_word_t'($urandom()), cfg_word_t'($urandom()),
                  cfg_word_t'($urandom()));
      end else begin
        configure(cfg_word_t'($urandom_range(0, 3)),
                  $urandom_range(0, 1) ? 24'h7FFFFF : 24'h000000,
                  $urandom_range(0, 1) ? 24'h800000 : 24'h000000,
                  $urandom_range(0, 1) ? 24'hFFFFFF : 24'h800000);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == 40) hold_off_reqs++;
        if (ph == 6 && n == 60) begin
          // Pause input until every outstanding response set is out
          din_if.valid = 1'b0;
          while (board.pending() != 0) @(posedge clk);
          @(negedge clk);
        end
        case ($urandom_range(0, 9)) inside
          [0:4]:   x = sample_t'($urandom());
          [5:6]:   x = sample_t'(int'($urandom_range(0, 8191)) - 4096);
          7:       x = SAMPLE_MAX;
          8:       x = SAMPLE_MIN;
          default: x = last_x;
        endcase
        last_x = x;
        put_sample(x);
      end
      drain();
    end

    if (board.failures == 0 && board.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
